// ===== hdl/tsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsdc_pkg
// Shared types and fixed-point constants for the tone-stack IIR / DC blocker.
// ----------------------------------------------------------------------------
`default_nettype none

package tsdc_pkg;

    // Fixed-point layout of the filter state and the blocker path
    localparam int STATE_W    = 48;   // section accumulators, 40 fraction bits
    localparam int STATE_FRAC = 40;
    localparam int DC_W       = 32;   // blocker values, 24 fraction bits
    localparam int DC_FRAC    = 24;
    localparam int YQ_SHIFT   = STATE_FRAC - DC_FRAC;

    // Rounded product widths (sized for 24-bit samples and 32-bit coefficients)
    localparam int PB_RND_W = 47;     // round(b * s) at 40 fraction bits
    localparam int PA_RND_W = 54;     // round(a * yq) at 40 fraction bits
    localparam int SUMH_W   = 49;     // h + round(b * s)
    localparam int DIFF_W   = 56;     // h + round(b * s) - round(a * yq)

    // DC blocker pole 0.990 in Q2.30
    localparam logic signed [DC_W-1:0] DC_POLE = 32'sd1063004406;
    localparam int DC_POLE_FRAC = 30;
    localparam int DC_PROD_W    = 2 * DC_W;
    localparam int DC_FB_W      = DC_W + 1;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_addr;
    localparam t_cfg_addr CFG_FF_BASE = 3'd0;   // b0..b3 at 0..3
    localparam t_cfg_addr CFG_FB_BASE = 3'd3;   // a1..a3 at 4..6

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_B,
        S_RND_B,
        S_SUM_Y,
        S_Y,
        S_MUL_A,
        S_RND_A,
        S_UPD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic mul_b;
        logic rnd_b;
        logic mul_a;
        logic rnd_a;
        logic upd;
    } t_cell_ctl;

    typedef struct packed {
        logic mul;
        logic rnd;
        logic upd;
    } t_dc_ctl;

endpackage

`default_nettype wire

// ===== hdl/tsdc_cell.sv =====
// ----------------------------------------------------------------------------
// tsdc_cell
// One transposed direct form II section: holds one delay term and updates it
// from its neighbor's term, b * sample and a * feedback value.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdc_cell
    import tsdc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  t_cell_ctl                       i_ctl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic signed [DC_W-1:0]     i_yq,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_a,
    input  wire logic signed [STATE_W-1:0]  i_accum_next,
    output logic signed [STATE_W-1:0]       o_accum
);

    localparam int PB_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int PA_W = COEF_WIDTH + DC_W;
    localparam int SHB  = (SAMPLE_WIDTH - 1) + (COEF_WIDTH - 5) - STATE_FRAC;
    localparam int SHA  = DC_FRAC + (COEF_WIDTH - 5) - STATE_FRAC;

    localparam logic signed [DIFF_W-1:0] ACC_MAX =
        $signed({{(DIFF_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}});
    localparam logic signed [DIFF_W-1:0] ACC_MIN =
        $signed({{(DIFF_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}});

    logic signed [PB_W-1:0]     r_prod_b;
    logic signed [PA_W-1:0]     r_prod_a;
    logic signed [PB_RND_W-1:0] r_pb_rnd;
    logic signed [PA_RND_W-1:0] r_pa_rnd;
    logic signed [SUMH_W-1:0]   r_sum;
    logic signed [STATE_W-1:0]  r_accum;

    logic signed [PB_RND_W-1:0] w_pb_rnd;
    logic signed [PA_RND_W-1:0] w_pa_rnd;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [STATE_W-1:0]  n_accum;

    // Round products to 40 fraction bits, half up
    generate
        if (SHB > 0) begin : g_pb_shr
            localparam logic signed [PB_W:0] HALF_B = (PB_W+1)'(1) <<< (SHB - 1);
            logic signed [PB_W:0] w_pb_biased;
            assign w_pb_biased = (PB_W+1)'(r_prod_b) + HALF_B;
            assign w_pb_rnd    = PB_RND_W'(w_pb_biased >>> SHB);
        end else begin : g_pb_shl
            assign w_pb_rnd = PB_RND_W'(r_prod_b) <<< (-SHB);
        end

        if (SHA > 0) begin : g_pa_shr
            localparam logic signed [PA_W:0] HALF_A = (PA_W+1)'(1) <<< (SHA - 1);
            logic signed [PA_W:0] w_pa_biased;
            assign w_pa_biased = (PA_W+1)'(r_prod_a) + HALF_A;
            assign w_pa_rnd    = PA_RND_W'(w_pa_biased >>> SHA);
        end else begin : g_pa_shl
            assign w_pa_rnd = PA_RND_W'(r_prod_a) <<< (-SHA);
        end
    endgenerate

    always_comb begin
        w_diff = DIFF_W'(r_sum) - DIFF_W'(r_pa_rnd);
        if (w_diff > ACC_MAX) begin
            n_accum = ACC_MAX[STATE_W-1:0];
        end else if (w_diff < ACC_MIN) begin
            n_accum = ACC_MIN[STATE_W-1:0];
        end else begin
            n_accum = w_diff[STATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_b) begin
            r_prod_b <= PB_W'(i_coef_b) * PB_W'(i_sample);
        end
        if (i_ctl.rnd_b) begin
            r_pb_rnd <= w_pb_rnd;
        end
        if (i_ctl.mul_a) begin
            r_prod_a <= PA_W'(i_coef_a) * PA_W'(i_yq);
        end
        if (i_ctl.rnd_a) begin
            r_sum    <= SUMH_W'(i_accum_next) + SUMH_W'(r_pb_rnd);
            r_pa_rnd <= w_pa_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (i_ctl.upd) begin
            r_accum <= n_accum;
        end
    end

    assign o_accum = r_accum;

endmodule

`default_nettype wire

// ===== hdl/tsdc_dc.sv =====
// ----------------------------------------------------------------------------
// tsdc_dc
// First-order DC blocker (pole 0.990) with output gain of two and saturation
// to the sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdc_dc
    import tsdc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_dc_ctl                     i_ctl,
    input  wire logic signed [DC_W-1:0] i_yq,
    output logic [SAMPLE_WIDTH-1:0]     o_sample
);

    localparam int SUM_W = DC_W + 3;
    localparam int OSH   = DC_FRAC - (SAMPLE_WIDTH - 1);
    localparam int D2_W  = DC_W + 1;
    localparam int OW    = (OSH > 0) ? (D2_W + 1) : (D2_W - OSH);

    localparam logic signed [DC_PROD_W-1:0] POLE_HALF =
        DC_PROD_W'(1) <<< (DC_POLE_FRAC - 1);
    localparam logic signed [SUM_W-1:0] D_MAX =
        $signed({{(SUM_W-DC_W+1){1'b0}}, {(DC_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] D_MIN =
        $signed({{(SUM_W-DC_W+1){1'b1}}, {(DC_W-1){1'b0}}});
    localparam logic signed [OW-1:0] O_MAX =
        $signed({{(OW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam logic signed [OW-1:0] O_MIN =
        $signed({{(OW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}});

    logic signed [DC_PROD_W-1:0] r_prod;
    logic signed [DC_FB_W-1:0]   r_fb;
    logic signed [DC_W-1:0]      r_prev_in;
    logic signed [DC_W-1:0]      r_prev_out;

    logic signed [DC_PROD_W-1:0] w_prod_biased;
    logic signed [SUM_W-1:0]     w_sum;
    logic signed [DC_W-1:0]      n_prev_out;
    logic signed [D2_W-1:0]      w_d2;
    logic signed [OW-1:0]        w_scaled;

    assign w_prod_biased = r_prod + POLE_HALF;

    always_comb begin
        w_sum = SUM_W'(i_yq) - SUM_W'(r_prev_in) + SUM_W'(r_fb);
        if (w_sum > D_MAX) begin
            n_prev_out = D_MAX[DC_W-1:0];
        end else if (w_sum < D_MIN) begin
            n_prev_out = D_MIN[DC_W-1:0];
        end else begin
            n_prev_out = w_sum[DC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= DC_PROD_W'(r_prev_out) * DC_PROD_W'(DC_POLE);
        end
        if (i_ctl.rnd) begin
            r_fb <= DC_FB_W'(w_prod_biased >>> DC_POLE_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_in  <= '0;
            r_prev_out <= '0;
        end else if (i_ctl.upd) begin
            r_prev_in  <= i_yq;
            r_prev_out <= n_prev_out;
        end
    end

    // Double, bring to the sample's fraction bits, round half up
    assign w_d2 = $signed({r_prev_out, 1'b0});

    generate
        if (OSH > 0) begin : g_out_shr
            localparam logic signed [OW-1:0] O_HALF = OW'(1) <<< (OSH - 1);
            logic signed [OW-1:0] w_biased;
            assign w_biased = OW'(w_d2) + O_HALF;
            assign w_scaled = w_biased >>> OSH;
        end else begin : g_out_shl
            assign w_scaled = OW'(w_d2) <<< (-OSH);
        end
    endgenerate

    always_comb begin
        if (w_scaled > O_MAX) begin
            o_sample = O_MAX[SAMPLE_WIDTH-1:0];
        end else if (w_scaled < O_MIN) begin
            o_sample = O_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            o_sample = w_scaled[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tone_stack_iir_dc_block.sv =====
// ----------------------------------------------------------------------------
// tone_stack_iir_dc_block
// Tone-stack IIR (transposed direct form II, order up to 3) followed by a
// DC blocker, output gain of two and saturation.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------
//  s_axis    | in  | tvalid / tready    | tdata: sample_in; tlast: block_end_in
//  m_axis    | out | tvalid / tready    | tdata: sample_out; tlast: block_end_out
//  cfg       | in  | we (no wait)       | addr: register index; wdata: coef
//
//  Each transaction, while the output is taken, runs through the accept cycle,
//  7 fixed sequencer steps (b*s and a*y products in every section cell,
//  rounding, head sum, cell update, blocker) and the load of the output register.
//  A result waits in the output register; the next input is taken meanwhile.
//  Reset sets b0 to 1.0, all other coefficients and all filter and blocker
//  state to zero; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_stack_iir_dc_block
    import tsdc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 32,
    parameter int FILTER_ORDER = 3
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    // input stream
    input  wire                                        i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   i_s_axis_tdata,  // sample_in
    input  wire                                        i_s_axis_tlast,  // block_end_in
    // output stream
    output logic                                       o_m_axis_tvalid,
    input  wire                                        i_m_axis_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]  o_m_axis_tdata,  // sample_out
    output logic                                       o_m_axis_tlast,  // block_end_out
    // configuration
    input  wire                                        i_cfg_we,
    input  wire t_cfg_addr                             i_cfg_addr,
    input  wire [COEF_WIDTH-1:0]                       i_cfg_wdata
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
        $signed({4'b0000, 1'b1, {(COEF_WIDTH-5){1'b0}}});

    t_state r_state, n_state;

    logic signed [COEF_WIDTH-1:0]   r_ff [0:FILTER_ORDER];
    logic signed [COEF_WIDTH-1:0]   r_fb [1:FILTER_ORDER];

    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_last;
    logic                           r_out_valid;
    logic [SAMPLE_WIDTH-1:0]        r_out_sample;
    logic                           r_out_last;

    t_cell_ctl                      w_head_ctl;
    t_cell_ctl                      w_cell_ctl;
    t_dc_ctl                        w_dc_ctl;
    logic                           w_load_out;
    logic                           w_in_accept;

    logic signed [STATE_W-1:0]      w_accum [0:FILTER_ORDER];
    logic signed [STATE_W-1:0]      w_y;
    logic signed [DC_W-1:0]         w_yq;
    logic [SAMPLE_WIDTH-1:0]        w_dc_sample;

    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // ---------------- coefficient registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FILTER_ORDER; k++) begin
                r_ff[k] <= (k == 0) ? COEF_ONE : '0;
            end
            for (int k = 1; k <= FILTER_ORDER; k++) begin
                r_fb[k] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int k = 0; k <= FILTER_ORDER; k++) begin
                if (i_cfg_addr == CFG_FF_BASE + 3'(k)) begin
                    r_ff[k] <= $signed(i_cfg_wdata);
                end
            end
            for (int k = 1; k <= FILTER_ORDER; k++) begin
                if (i_cfg_addr == CFG_FB_BASE + 3'(k)) begin
                    r_fb[k] <= $signed(i_cfg_wdata);
                end
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_head_ctl = '0;
        w_cell_ctl = '0;
        w_dc_ctl   = '0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_MUL_B;
                end
            end
            S_MUL_B: begin
                w_head_ctl.mul_b = 1'b1;
                w_head_ctl.mul_a = 1'b1;   // clears the head's unused feedback term
                w_cell_ctl.mul_b = 1'b1;
                w_dc_ctl.mul     = 1'b1;
                n_state          = S_RND_B;
            end
            S_RND_B: begin
                w_head_ctl.rnd_b = 1'b1;
                w_cell_ctl.rnd_b = 1'b1;
                w_dc_ctl.rnd     = 1'b1;
                n_state          = S_SUM_Y;
            end
            S_SUM_Y: begin
                w_head_ctl.rnd_a = 1'b1;
                n_state          = S_Y;
            end
            S_Y: begin
                w_head_ctl.upd = 1'b1;
                n_state        = S_MUL_A;
            end
            S_MUL_A: begin
                w_cell_ctl.mul_a = 1'b1;
                w_dc_ctl.upd     = 1'b1;
                n_state          = S_RND_A;
            end
            S_RND_A: begin
                w_cell_ctl.rnd_a = 1'b1;
                n_state          = S_UPD;
            end
            S_UPD: begin
                w_cell_ctl.upd = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- input capture ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sample <= $signed(i_s_axis_tdata[SAMPLE_WIDTH-1:0]);
            r_last   <= i_s_axis_tlast;
        end
    end

    // ---------------- section chain ----------------
    assign w_accum[FILTER_ORDER] = '0;

    // head: y = sat(h0 + b0 * s)
    tsdc_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_head (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_head_ctl),
        .i_sample     (r_sample),
        .i_yq         ('0),
        .i_coef_b     (r_ff[0]),
        .i_coef_a     ('0),
        .i_accum_next (w_accum[0]),
        .o_accum      (w_y)
    );

    assign w_yq = $signed(w_y[STATE_W-1:YQ_SHIFT]);

    generate
        for (genvar k = 0; k < FILTER_ORDER; k++) begin : g_cell
            tsdc_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .COEF_WIDTH   (COEF_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_cell_ctl),
                .i_sample     (r_sample),
                .i_yq         (w_yq),
                .i_coef_b     (r_ff[k+1]),
                .i_coef_a     (r_fb[k+1]),
                .i_accum_next (w_accum[k+1]),
                .o_accum      (w_accum[k])
            );
        end
    endgenerate

    // ---------------- DC blocker ----------------
    tsdc_dc #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_dc_ctl),
        .i_yq     (w_yq),
        .o_sample (w_dc_sample)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_sample <= w_dc_sample;
            r_out_last   <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out_sample);
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== sim/tb_tone_stack_iir_dc_block.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_stack_iir_dc_block
// Self-checking bench for the tone-stack IIR filter with DC blocker. Drives
// audio sample streams through several coefficient sets (reset default,
// all-max, all-min, zero, a realistic low-pass, random stable and random wild
// sets). A bit-exact fixed-point predictor of the filter, blocker and output
// stage checks every output transaction. Both streams idle and stall at random.
// ----------------------------------------------------------------------------

module tb_tone_stack_iir_dc_block;
    import tsdc_pkg::*;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int ORDER    = 3;
    localparam int BUS_W    = ((SAMPLE_W + 7) / 8) * 8;

    // fraction bits dropped when rounding b*s and a*yq to the state format
    localparam int B_PROD_SHIFT = (SAMPLE_W - 1) + (COEF_W - 5) - STATE_FRAC;
    localparam int A_PROD_SHIFT = DC_FRAC + (COEF_W - 5) - STATE_FRAC;
    localparam int OUT_SHIFT    = DC_FRAC - (SAMPLE_W - 1);
    localparam int OUT_GAIN     = 2;

    localparam int SETTLE_CYCLES = 20;
    localparam int ONE_Q27       = 1 << (COEF_W - 5);

    localparam t_cfg_addr REG_B0     = CFG_FF_BASE;
    localparam t_cfg_addr REG_B3     = CFG_FF_BASE + 3'd3;
    localparam t_cfg_addr REG_A1     = CFG_FB_BASE + 3'd1;
    localparam t_cfg_addr REG_A3     = CFG_FB_BASE + 3'd3;
    localparam t_cfg_addr REG_UNUSED = 3'd7;

    localparam logic [4:0][SAMPLE_W-1:0] EXTREME_SAMPLES =
        {24'h7fffff, 24'h800000, 24'h000000, 24'h000001, 24'hffffff};

    typedef logic [6:0][COEF_W-1:0] t_coef_set;   // indexed by register index

    typedef enum {
        SET_BYPASS, SET_TONE, SET_STABLE, SET_WILD, SET_MAX, SET_MIN, SET_ZERO
    } t_coef_kind;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                last;
    } t_audio_item;

    class tone_dc_scoreboard;
        longint      ff_coef [4];
        longint      fb_coef [4];
        longint      accum [ORDER];
        longint      blk_prev_in;
        longint      blk_prev_out;
        t_audio_item expected_out [$];
        int          failures;
        int          n_checked;
        int          n_clipped;
        int          n_block_ends;

        function new();
            foreach (ff_coef[i]) ff_coef[i] = 0;
            foreach (fb_coef[i]) fb_coef[i] = 0;
            foreach (accum[i]) accum[i] = 0;
            ff_coef[0]   = ONE_Q27;
            blk_prev_in  = 0;
            blk_prev_out = 0;
            failures     = 0;
            n_checked    = 0;
            n_clipped    = 0;
            n_block_ends = 0;
        endfunction

        static function longint round_shift(longint v, int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        static function longint clip(longint v, int w);
            longint hi;
            hi = (64'sd1 <<< (w - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function void set_coef(t_cfg_addr idx, logic [COEF_W-1:0] val);
            if (idx >= REG_B0 && idx <= REG_B3)
                ff_coef[idx - REG_B0] = longint'(signed'(val));
            else if (idx >= REG_A1 && idx <= REG_A3)
                fb_coef[idx - CFG_FB_BASE] = longint'(signed'(val));
            // any other index leaves the coefficients alone
        endfunction

        function int pending();
            return expected_out.size();
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10)
                $display("[%0t] FAIL: %s", $realtime, what);
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] smp, logic last);
            longint      s;
            longint      y;
            longint      yq;
            longint      d;
            longint      o;
            t_audio_item item;
            s  = longint'(signed'(smp));
            y  = clip(accum[0] + round_shift(ff_coef[0] * s, B_PROD_SHIFT), STATE_W);
            yq = y >>> YQ_SHIFT;
            // transposed form: each delay term takes the next one plus its taps
            for (int i = 1; i < ORDER; i++)
                accum[i-1] = clip(accum[i] + round_shift(ff_coef[i] * s, B_PROD_SHIFT)
                                  - round_shift(fb_coef[i] * yq, A_PROD_SHIFT), STATE_W);
            accum[ORDER-1] = clip(round_shift(ff_coef[ORDER] * s, B_PROD_SHIFT)
                                  - round_shift(fb_coef[ORDER] * yq, A_PROD_SHIFT), STATE_W);
            d = yq - blk_prev_in
                + round_shift(blk_prev_out * longint'(DC_POLE), DC_POLE_FRAC);
            d = clip(d, DC_W);
            blk_prev_in  = yq;
            blk_prev_out = d;
            o = clip(round_shift(d * OUT_GAIN, OUT_SHIFT), SAMPLE_W);
            if (o == (64'sd1 <<< (SAMPLE_W - 1)) - 1 || o == -(64'sd1 <<< (SAMPLE_W - 1)))
                n_clipped++;
            item.smp  = o[SAMPLE_W-1:0];
            item.last = last;
            expected_out.push_back(item);
        endfunction

        function void check_sample(logic [SAMPLE_W-1:0] smp, logic last);
            t_audio_item exp_item;
            if (expected_out.size() == 0) begin
                note_failure($sformatf("unexpected output sample %0d last %0b",
                                       $signed(smp), last));
                return;
            end
            exp_item = expected_out.pop_front();
            n_checked++;
            if (last) n_block_ends++;
            if (smp !== exp_item.smp || last !== exp_item.last)
                note_failure($sformatf("sample exp %0d got %0d, last exp %0b got %0b",
                                       $signed(exp_item.smp), $signed(smp),
                                       exp_item.last, last));
        endfunction

        function void close_out();
            if (expected_out.size() != 0)
                note_failure($sformatf("%0d expected samples never came out",
                                       expected_out.size()));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic [BUS_W-1:0]    s_data = '0;
    logic                s_last = 1'b0;
    logic                m_ready = 1'b0;
    logic                cfg_we = 1'b0;
    t_cfg_addr           cfg_addr = REG_B0;
    logic [COEF_W-1:0]   cfg_wdata = '0;

    wire                 o_s_axis_tready;
    wire                 o_m_axis_tvalid;
    wire [BUS_W-1:0]     o_m_axis_tdata;
    wire                 o_m_axis_tlast;

    bit                  tx_idle_on = 1'b0;
    bit                  rx_stall_on = 1'b0;
    int                  rx_hold = 0;
    int                  audio_level = 0;
    int                  n_coef_sets = 1;

    tone_dc_scoreboard   sb;

    tone_stack_iir_dc_block #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .COEF_WIDTH   (COEF_W),
        .FILTER_ORDER (ORDER)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: check completed transactions, then pick next cycle's ready
    always @(posedge clk) begin
        if (rst_n && o_m_axis_tvalid && m_ready)
            sb.check_sample(o_m_axis_tdata[SAMPLE_W-1:0], o_m_axis_tlast);
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 99) < 25) begin
            rx_hold <= idle_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= BUS_W'(smp);
        s_last  <= last;
        @(posedge clk);
        while (!o_s_axis_tready) @(posedge clk);
        sb.note_sample(smp, last);
    endtask

    // drop valid, then wait until every expected sample has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_coefs(input t_coef_set set, input bit stray_write);
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_B0 + t_cfg_addr'(i);
            cfg_wdata <= set[i];
            @(posedge clk);
            sb.set_coef(REG_B0 + t_cfg_addr'(i), set[i]);
        end
        if (stray_write) begin
            // unmapped index: must not disturb any coefficient
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_UNUSED;
            cfg_wdata <= $urandom();
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        n_coef_sets++;
    endtask

    function automatic t_coef_set make_coefs(t_coef_kind kind);
        t_coef_set set;
        set = '0;
        case (kind)
            SET_BYPASS: set[0] = ONE_Q27;
            SET_TONE: begin
                // low-pass with a triple pole at 0.5
                set[0] = 32'sd6710886;
                set[1] = 32'sd20132659;
                set[2] = 32'sd20132659;
                set[3] = 32'sd6710886;
                set[4] = -32'sd201326592;
                set[5] = 32'sd100663296;
                set[6] = -32'sd16777216;
            end
            SET_STABLE: begin
                for (int i = 0; i < 4; i++)
                    set[i] = int'($urandom_range(0, 1 << 29)) - (1 << 28);
                for (int i = 4; i < 7; i++)
                    set[i] = int'($urandom_range(0, 1 << 26)) - (1 << 25);
            end
            SET_WILD: for (int i = 0; i < 7; i++) set[i] = $urandom();
            SET_MAX:  for (int i = 0; i < 7; i++) set[i] = 32'h7fffffff;
            SET_MIN:  for (int i = 0; i < 7; i++) set[i] = 32'h80000000;
            default:  set = '0;
        endcase
        return set;
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_audio_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return SAMPLE_W'($urandom());
        if (pick < 6) return SAMPLE_W'(int'($urandom_range(0, 2047)) - 1024);
        if (pick == 6) return EXTREME_SAMPLES[$urandom_range(0, 4)];
        // slow wander, gives the blocker real low-frequency content
        audio_level = audio_level + int'($urandom_range(0, 1 << 16)) - (1 << 15);
        if (audio_level > 8388607) audio_level = 8388607;
        if (audio_level < -8388608) audio_level = -8388608;
        return SAMPLE_W'(audio_level);
    endfunction

    // buffers of random length closed by a block-end mark, some with stray marks
    task automatic run_audio(input int count);
        int left;
        int len;
        bit noisy;
        left = count;
        while (left > 0) begin
            len = $urandom_range(1, 64);
            if (len > left) len = left;
            noisy = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++)
                send_sample(next_audio_sample(),
                            noisy ? 1'($urandom_range(0, 1)) : (k == len - 1));
            left -= len;
        end
    endtask

    initial begin
        t_coef_kind plan [8];
        plan = '{SET_TONE, SET_STABLE, SET_WILD, SET_STABLE,
                 SET_TONE, SET_WILD, SET_STABLE, SET_BYPASS};
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;

        // reset coefficients: straight through the blocker, held full scale
        for (int i = 0; i < 5; i++) send_sample(EXTREME_SAMPLES[i], i == 4);
        repeat (3) send_sample(24'h7fffff, 1'b0);
        repeat (3) send_sample(24'h800000, 1'b1);
        wait_drained();

        load_coefs(make_coefs(SET_MAX), 1'b1);
        for (int i = 0; i < 5; i++) send_sample(EXTREME_SAMPLES[i], i == 4);
        wait_drained();

        load_coefs(make_coefs(SET_MIN), 1'b0);
        for (int i = 0; i < 5; i++) send_sample(EXTREME_SAMPLES[i], i == 4);
        wait_drained();

        // no feedforward at all: only the blocker's memory decays
        load_coefs(make_coefs(SET_ZERO), 1'b0);
        run_audio(40);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            tx_idle_on  = (p % 3 == 1);
            rx_stall_on = (p % 3 != 0);
            load_coefs(make_coefs(plan[p]), plan[p] == SET_WILD);
            run_audio(140);
            wait_drained();
        end
        wait_drained();

        sb.close_out();
        $display("checked %0d output samples (%0d block ends, %0d at full scale)",
                 sb.n_checked, sb.n_block_ends, sb.n_clipped);
        $display("over %0d coefficient sets with random idling and back-pressure",
                 n_coef_sets);
        if (sb.failures == 0) begin
            $display("tb_tone_stack_iir_dc_block: clean");
        end else begin
            $display("%0d failures in total", sb.failures);
            $display("tb_tone_stack_iir_dc_block: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout waiting on the stream handshakes");
        $display("tb_tone_stack_iir_dc_block: errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tsdc_pkg.sv
hdl/tsdc_cell.sv
hdl/tsdc_dc.sv
hdl/tone_stack_iir_dc_block.sv
sim/tb_tone_stack_iir_dc_block.sv
